[hw/rtl/multi_led_blink_controller_assert.svh]
// Assertion macros used by the blink controller RTL.
`ifndef MULTI_LED_BLINK_CONTROLLER_ASSERT_SVH
`define MULTI_LED_BLINK_CONTROLLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define MLB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlb same-cycle check failed");
`define MLB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlb next-cycle check failed");
`else
`define MLB_ASSERT_SAME(lbl, ante, cons)
`define MLB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/mlb_pkg.sv]
// Shared types and constants of the multi-LED blink controller.
`timescale 1ns / 1ps
package mlb_pkg;

  localparam int MLB_MAX_LEDS = 8;

  localparam logic [3:0]  RST_LED_COUNT     = 4'd8;
  localparam logic [15:0] RST_LONG_ON_MS    = 16'd1000;
  localparam logic [15:0] RST_LONG_OFF_MS   = 16'd1000;
  localparam logic [15:0] RST_SHORT_HALF_MS = 16'd200;
  localparam logic [15:0] RST_ERROR_ON_MS   = 16'd100;
  localparam logic [15:0] RST_ERROR_OFF_MS  = 16'd100;
  localparam logic [7:0]  RST_ERROR_FLASHES = 8'd5;

  typedef enum logic [2:0] {
    ACT_ON    = 3'd0,
    ACT_OFF   = 3'd1,
    ACT_LONG  = 3'd2,
    ACT_SHORT = 3'd3,
    ACT_ERROR = 3'd4,
    ACT_TICK  = 3'd5
  } mlb_action_t;

  typedef enum logic [2:0] {
    REG_LED_COUNT     = 3'd0,
    REG_LONG_ON_MS    = 3'd1,
    REG_LONG_OFF_MS   = 3'd2,
    REG_SHORT_HALF_MS = 3'd3,
    REG_ERROR_ON_MS   = 3'd4,
    REG_ERROR_OFF_MS  = 3'd5,
    REG_ERROR_FLASHES = 3'd6
  } mlb_reg_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_ERROR = 2'd3
  } mlb_mode_t;

  typedef struct packed {
    logic [3:0]  led_count;
    logic [15:0] long_on_ms;
    logic [15:0] long_off_ms;
    logic [15:0] short_half_ms;
    logic [15:0] error_on_ms;
    logic [15:0] error_off_ms;
    logic [7:0]  error_flashes;
  } mlb_cfg_t;

  // One LED entry of the state memory.
  typedef struct packed {
    mlb_mode_t   mode;
    logic [31:0] last_change;
    logic [15:0] on_period;
    logic [15:0] off_period;
    logic [7:0]  flashes_left;
  } mlb_entry_t;

endpackage

[hw/rtl/multi_led_blink_controller.sv]
// An applied command passes through S_CMD and S_FINISH, a tick through S_WALK and S_FINISH;
// an ignored command, an unused code or a tick with no LEDs in use goes straight to S_FINISH.
// A new command or tick is taken only in S_IDLE, after the last result is registered; the walk
// reads and writes back one LED entry of the state memory per cycle.
// Reset (synchronous, rst high): all LEDs off, pins low, registers at their defaults;
// per-entry valid flags make unwritten entries read as off with a zero change time.
`timescale 1ns / 1ps
`include "multi_led_blink_controller_assert.svh"
module multi_led_blink_controller #(
  parameter int MAX_LEDS = mlb_pkg::MLB_MAX_LEDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [2:0]  led_index,
  input  logic [31:0] current_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  led_outputs,
  output logic        index_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mlb_pkg::*;

  localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W = $clog2(MAX_LEDS + 1);
  localparam int EW    = $bits(mlb_entry_t);

  typedef enum logic [1:0] {S_IDLE, S_CMD, S_WALK, S_FINISH} state_t;

  state_t             state;
  mlb_cfg_t           cfg;
  mlb_action_t        act_q;
  logic [31:0]        now_q;
  logic               ok_q;
  logic [AW-1:0]      cur;
  logic [MAX_LEDS-1:0] pins;
  logic [MAX_LEDS-1:0] entry_valid;
  logic               rd_valid_q;

  logic [CNT_W-1:0]   count;
  logic               accept;
  logic               is_tick;
  logic               cmd_ok;
  logic               walk_last;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [EW-1:0]      rd_data;
  logic               wr_en;
  mlb_entry_t         ent_rd;
  mlb_entry_t         ent_cur;
  mlb_entry_t         ent_upd;
  logic               pin_upd;
  logic [31:0]        elapsed;

  mlb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mlb_ram #(
    .DEPTH (MAX_LEDS),
    .AW    (AW),
    .W     (EW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur),
    .wr_data (ent_upd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign count = (32'(cfg.led_count) > 32'(MAX_LEDS)) ? CNT_W'(MAX_LEDS)
                                                       : CNT_W'(cfg.led_count);

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_tick   = (action == ACT_TICK);
  assign cmd_ok    = (action <= ACT_ERROR) && (32'(led_index) < 32'(count));
  assign walk_last = (32'(cur) + 32'd1) >= 32'(count);
  assign wr_en     = (state == S_CMD) || (state == S_WALK);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur;
    case (state)
      S_IDLE: begin
        if (accept && is_tick && (count != '0)) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end else if (accept && !is_tick && cmd_ok) begin
          rd_en   = 1'b1;
          rd_addr = AW'(led_index);
        end
      end
      S_WALK: begin
        // prefetch the next LED while this one is written back
        if (!walk_last) begin
          rd_en   = 1'b1;
          rd_addr = cur + AW'(1);
        end
      end
      default: ;
    endcase
  end

  assign ent_rd = mlb_entry_t'(rd_data);

  always_comb begin
    ent_cur = ent_rd;
    if (!rd_valid_q) begin
      ent_cur.mode        = MODE_OFF;
      ent_cur.last_change = '0;
    end
  end

  assign elapsed = now_q - ent_cur.last_change;

  always_comb begin
    ent_upd = ent_cur;
    pin_upd = pins[cur];
    if (state == S_CMD) begin
      case (act_q)
        ACT_ON: begin
          pin_upd      = 1'b1;
          ent_upd.mode = MODE_ON;
        end
        ACT_OFF: begin
          pin_upd      = 1'b0;
          ent_upd.mode = MODE_OFF;
        end
        ACT_LONG: begin
          ent_upd.on_period  = cfg.long_on_ms;
          ent_upd.off_period = cfg.long_off_ms;
          ent_upd.mode       = MODE_BLINK;
        end
        ACT_SHORT: begin
          ent_upd.on_period  = cfg.short_half_ms;
          ent_upd.off_period = cfg.short_half_ms;
          ent_upd.mode       = MODE_BLINK;
        end
        default: begin
          ent_upd.on_period    = cfg.error_on_ms;
          ent_upd.off_period   = cfg.error_off_ms;
          ent_upd.flashes_left = cfg.error_flashes;
          ent_upd.mode         = MODE_ERROR;
        end
      endcase
    end else if (ent_cur.mode == MODE_ERROR && ent_cur.flashes_left == '0) begin
      // error blink used up: drop to off without a toggle
      ent_upd.mode = MODE_OFF;
      pin_upd      = 1'b0;
    end else if (ent_cur.mode == MODE_BLINK || ent_cur.mode == MODE_ERROR) begin
      if (pins[cur]) begin
        if (elapsed >= 32'(ent_cur.on_period)) begin
          pin_upd             = 1'b0;
          ent_upd.last_change = now_q;
          if (ent_cur.mode == MODE_ERROR) begin
            ent_upd.flashes_left = ent_cur.flashes_left - 8'd1;
          end
        end
      end else if (elapsed >= 32'(ent_cur.off_period)) begin
        pin_upd             = 1'b1;
        ent_upd.last_change = now_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      pins        <= '0;
      entry_valid <= '0;
    end else begin
      rd_valid_q <= entry_valid[rd_addr];
      // a new result in S_FINISH replaces the one taken this cycle
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        pins[cur]        <= pin_upd;
        entry_valid[cur] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            act_q <= mlb_action_t'(action);
            now_q <= current_time;
            ok_q  <= is_tick || cmd_ok;
            cur   <= is_tick ? '0 : AW'(led_index);
            if (is_tick) begin
              state <= (count == '0) ? S_FINISH : S_WALK;
            end else begin
              state <= cmd_ok ? S_CMD : S_FINISH;
            end
          end
        end
        S_CMD: begin
          state <= S_FINISH;
        end
        S_WALK: begin
          if (walk_last) begin
            state <= S_FINISH;
          end else begin
            cur <= cur + AW'(1);
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            led_outputs <= 8'(pins);
            index_ok    <= ok_q;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MLB_ASSERT_SAME(a_no_same_entry, wr_en && rd_en, rd_addr != cur)
  `MLB_ASSERT_NEXT(a_read_consumed, rd_en, state == S_WALK || state == S_CMD)
  `MLB_ASSERT_NEXT(a_one_item, accept, !in_ready)
  `MLB_ASSERT_SAME(a_walk_in_range, state == S_WALK, 32'(cur) < 32'(count))

endmodule

[hw/rtl/mlb_cfg.sv]
// Configuration register file of the blink controller.
`timescale 1ns / 1ps
module mlb_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output mlb_pkg::mlb_cfg_t cfg
);
  import mlb_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_count     <= RST_LED_COUNT;
      cfg.long_on_ms    <= RST_LONG_ON_MS;
      cfg.long_off_ms   <= RST_LONG_OFF_MS;
      cfg.short_half_ms <= RST_SHORT_HALF_MS;
      cfg.error_on_ms   <= RST_ERROR_ON_MS;
      cfg.error_off_ms  <= RST_ERROR_OFF_MS;
      cfg.error_flashes <= RST_ERROR_FLASHES;
    end else if (cfg_valid && cfg_ready) begin
      case (mlb_reg_t'(cfg_index))
        REG_LED_COUNT:     cfg.led_count     <= cfg_data[3:0];
        REG_LONG_ON_MS:    cfg.long_on_ms    <= cfg_data;
        REG_LONG_OFF_MS:   cfg.long_off_ms   <= cfg_data;
        REG_SHORT_HALF_MS: cfg.short_half_ms <= cfg_data;
        REG_ERROR_ON_MS:   cfg.error_on_ms   <= cfg_data;
        REG_ERROR_OFF_MS:  cfg.error_off_ms  <= cfg_data;
        REG_ERROR_FLASHES: cfg.error_flashes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/mlb_ram.sv]
// Single-port-write, single-port-read state memory with registered read data.
`timescale 1ns / 1ps
module mlb_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int W     = 74
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
